// ===== hw/rtl/sitr_pkg.sv =====
// Shared constants, codes and types for the signed integer to radix text core.
// No dependencies; every other file but sitr_checker imports this package.
`default_nettype none

package sitr_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int MAX_BASE    = 16;
  localparam int CHAR_W      = 8;
  localparam int CFG_DATA_W  = 64;
  localparam int BASE_W      = 5;
  localparam int ALPHA_IDX_W = 4;
  localparam int DIGIT_W     = $clog2(MAX_BASE);
  localparam int RADIX_W     = DIGIT_W + 1;
  localparam int CNT_W       = $clog2(VALUE_WIDTH + 1);
  localparam int PTR_W       = $clog2(VALUE_WIDTH);
  localparam int CFG_IDX_W   = 2;

  localparam logic [CHAR_W-1:0]     MINUS_CHAR      = 8'h2D;
  localparam logic [BASE_W-1:0]     BASE_SIZE_RST   = 5'd10;
  localparam logic [CFG_DATA_W-1:0] DIGITS_LOW_RST  = 64'h3736353433323130;
  localparam logic [CFG_DATA_W-1:0] DIGITS_HIGH_RST = 64'h0000000000003938;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_BASE_SIZE   = 2'd0;
  localparam cfg_idx_t CFG_DIGITS_LOW  = 2'd1;
  localparam cfg_idx_t CFG_DIGITS_HIGH = 2'd2;

  typedef logic signed [VALUE_WIDTH-1:0] value_t;
  typedef logic [VALUE_WIDTH-1:0]        mag_t;
  typedef logic [CHAR_W-1:0]             char_t;
  typedef logic [DIGIT_W-1:0]            digit_t;
  typedef logic [RADIX_W-1:0]            radix_t;
  typedef logic [CNT_W-1:0]              cnt_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_SIGN,
    ST_DIGITS
  } state_t;

  typedef struct packed {
    logic start;
    mag_t dividend;
  } div_req_t;

  typedef struct packed {
    logic   done;
    mag_t   quotient;
    digit_t remainder;
  } div_rsp_t;

  typedef struct packed {
    logic   push;
    logic   pop;
    digit_t digit;
  } stk_ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sitr_if.sv =====
// Request channel interfaces: integer in, characters out.
// Depends on sitr_pkg.
`default_nettype none

interface sitr_in_if;
  import sitr_pkg::*;
  logic   valid;
  logic   ready;
  value_t value;
  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

interface sitr_out_if;
  import sitr_pkg::*;
  logic  valid;
  logic  ready;
  char_t character;
  logic  last;
  modport source (output valid, output character, output last, input ready);
  modport sink (input valid, input character, input last, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/sitr_divider.sv =====
// Bit-serial restoring divider: magnitude by radix, one quotient bit per cycle.
// Depends on sitr_pkg.
`default_nettype none

module sitr_divider (
  input  logic              clk,
  input  logic              rst_n,
  input  sitr_pkg::radix_t  radix,
  input  sitr_pkg::div_req_t req,
  output sitr_pkg::div_rsp_t rsp
);
  import sitr_pkg::*;

  mag_t   q_r, q_nxt;
  digit_t rem_r, rem_nxt;
  cnt_t   cnt_r, cnt_nxt;
  logic   busy_r, busy_nxt;
  logic   done_r, done_nxt;
  logic [RADIX_W-1:0] shifted;
  logic   ge;

  always_comb begin
    shifted  = {rem_r, q_r[VALUE_WIDTH-1]};
    ge       = (shifted >= radix);
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      q_nxt    = req.dividend;
      rem_nxt  = '0;
      cnt_nxt  = CNT_W'(VALUE_WIDTH);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      q_nxt   = {q_r[VALUE_WIDTH-2:0], ge};
      rem_nxt = ge ? DIGIT_W'(shifted - radix) : shifted[DIGIT_W-1:0];
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = q_r;
  assign rsp.remainder = rem_r;

endmodule

`default_nettype wire

// ===== hw/rtl/sitr_digit_stack.sv =====
// Digit stack: remainders pushed least significant first, popped most significant first.
// Depends on sitr_pkg.
`default_nettype none

module sitr_digit_stack (
  input  logic               clk,
  input  logic               rst_n,
  input  sitr_pkg::stk_ctl_t ctl,
  output sitr_pkg::digit_t   top_digit,
  output sitr_pkg::cnt_t     count
);
  import sitr_pkg::*;

  digit_t mem [VALUE_WIDTH];
  digit_t top_r;
  cnt_t   cnt_r, cnt_nxt;
  cnt_t   below_pos;

  always_comb begin
    below_pos = cnt_r - CNT_W'(2);
    cnt_nxt   = cnt_r;
    if (ctl.push) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (ctl.pop) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    if (ctl.push) begin
      mem[cnt_r[PTR_W-1:0]] <= ctl.digit;
      top_r <= ctl.digit;
    end else if (ctl.pop) begin
      top_r <= mem[below_pos[PTR_W-1:0]];
    end
  end

  assign top_digit = top_r;
  assign count     = cnt_r;

endmodule

`default_nettype wire

// ===== hw/rtl/signed_integer_to_radix_text_core.sv =====
// Top level: signed integer to radix text, control, configuration and output register.
// Depends on sitr_pkg, sitr_if, sitr_divider and sitr_digit_stack.
//
//   channel | dir | payload                 | handshake
//   in_ch   | in  | value (32b signed)      | valid/ready request
//   out_ch  | out | character (8b), last    | valid/ready request
//   cfg_*   | in  | cfg_index, cfg_data     | cfg_we, no back-pressure
//
// Each digit takes a full pass of the bit-serial divider over the remaining quotient.
// One value in flight; the next is taken while the previous last character waits.
// rst_n is synchronous; it restores radix 10 and alphabet "0123456789".
// Output stalls hold the character register and stop the sign and digit output only.
`default_nettype none

module signed_integer_to_radix_text_core (
  input  logic                                  clk,
  input  logic                                  rst_n,
  sitr_in_if.sink                               in_ch,
  sitr_out_if.source                            out_ch,
  input  logic                                  cfg_we,
  input  sitr_pkg::cfg_idx_t                    cfg_index,
  input  logic [sitr_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import sitr_pkg::*;

  state_t state_r, state_nxt;
  logic   neg_r, neg_nxt;
  logic   out_valid_r, out_valid_nxt;
  char_t  out_char_r, out_char_nxt;
  logic   out_last_r, out_last_nxt;
  logic [BASE_W-1:0]     base_size_r;
  logic [CFG_DATA_W-1:0] chars_low_r, chars_high_r;

  radix_t   radix;
  div_req_t div_req;
  div_rsp_t div_rsp;
  stk_ctl_t stk_ctl;
  digit_t   top_digit;
  cnt_t     stk_count;
  logic     out_free;
  logic     in_neg;
  logic [2*CFG_DATA_W-1:0]  alphabet;
  logic [ALPHA_IDX_W-1:0]   alpha_idx;
  char_t    digit_char;

  sitr_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .radix (radix),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  sitr_digit_stack u_stack (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (stk_ctl),
    .top_digit (top_digit),
    .count     (stk_count)
  );

  always_comb begin
    if (base_size_r < BASE_W'(2)) begin
      radix = RADIX_W'(2);
    end else if (base_size_r > BASE_W'(MAX_BASE)) begin
      radix = RADIX_W'(MAX_BASE);
    end else begin
      radix = base_size_r[RADIX_W-1:0];
    end
  end

  assign alphabet   = {chars_high_r, chars_low_r};
  assign alpha_idx  = ALPHA_IDX_W'(top_digit);
  assign digit_char = alphabet[{alpha_idx, 3'b000} +: CHAR_W];
  assign out_free   = !out_valid_r || out_ch.ready;
  assign in_neg     = in_ch.value[VALUE_WIDTH-1];

  always_comb begin
    state_nxt        = state_r;
    neg_nxt          = neg_r;
    out_valid_nxt    = out_valid_r && !out_ch.ready;
    out_char_nxt     = out_char_r;
    out_last_nxt     = out_last_r;
    in_ch.ready      = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = div_rsp.quotient;
    stk_ctl.push     = 1'b0;
    stk_ctl.pop      = 1'b0;
    stk_ctl.digit    = div_rsp.remainder;
    case (state_r)
      ST_IDLE: begin
        in_ch.ready      = 1'b1;
        div_req.dividend = in_neg ? mag_t'(~in_ch.value + 1'b1) : mag_t'(in_ch.value);
        if (in_ch.valid) begin
          div_req.start = 1'b1;
          neg_nxt       = in_neg;
          state_nxt     = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (div_rsp.done) begin
          stk_ctl.push = 1'b1;
          if (div_rsp.quotient == '0) begin
            state_nxt = neg_r ? ST_SIGN : ST_DIGITS;
          end else begin
            div_req.start = 1'b1;
          end
        end
      end
      ST_SIGN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = MINUS_CHAR;
          out_last_nxt  = 1'b0;
          state_nxt     = ST_DIGITS;
        end
      end
      ST_DIGITS: begin
        if (out_free) begin
          stk_ctl.pop   = 1'b1;
          out_valid_nxt = 1'b1;
          out_char_nxt  = digit_char;
          out_last_nxt  = (stk_count == CNT_W'(1));
          if (stk_count == CNT_W'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_valid_r  <= 1'b0;
      base_size_r  <= BASE_SIZE_RST;
      chars_low_r  <= DIGITS_LOW_RST;
      chars_high_r <= DIGITS_HIGH_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_BASE_SIZE:   base_size_r  <= cfg_data[BASE_W-1:0];
          CFG_DIGITS_LOW:  chars_low_r  <= cfg_data;
          CFG_DIGITS_HIGH: chars_high_r <= cfg_data;
          default: begin
          end
        endcase
      end
    end
    neg_r      <= neg_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.character = out_char_r;
  assign out_ch.last      = out_last_r;

endmodule

`default_nettype wire

// ===== hw/rtl/sitr_checker.sv =====
// Port-level checks for the signed integer to radix text core, with its bind.
// Depends on signed_integer_to_radix_text_core and its channel interfaces.
`default_nettype none

module sitr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_character,
  input logic       out_last
);

  logic [1:0] pend_r, pend_nxt;
  logic       in_acc, out_done;

  assign in_acc   = in_valid && in_ready;
  assign out_done = out_valid && out_ready && out_last;

  always_comb begin
    pend_nxt = pend_r;
    if (in_acc && !out_done) begin
      pend_nxt = pend_r + 2'd1;
    end else if (out_done && !in_acc) begin
      pend_nxt = pend_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_character) && $stable(out_last))
    else $error("output request changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("input taken again straight after a request");

  a_no_spurious_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 2'd0)
    else $error("character shown with no value outstanding");

  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r != 2'd3)
    else $error("more than two values outstanding");

endmodule

bind signed_integer_to_radix_text_core sitr_checker u_sitr_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_character (out_ch.character),
  .out_last      (out_ch.last)
);

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking bench for signed_integer_to_radix_text_core: integers in, radix text out.
// Holds its own radix conversion predictor in a scoreboard class; needs sitr_pkg, sitr_if
// and the core with its submodules.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sitr_pkg::*;

  localparam int STALL_LIMIT = 20000;
  localparam int TAIL_CYCLES = 400;
  localparam int PHASE_ITEMS = 40;

  localparam cfg_idx_t CFG_SPARE = 2'd3;

  localparam logic [CFG_DATA_W-1:0] HEX_LOW  = 64'h3736353433323130;
  localparam logic [CFG_DATA_W-1:0] HEX_HIGH = 64'h4645444342413938;

  localparam value_t MOST_NEGATIVE = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
  localparam value_t MOST_POSITIVE = {1'b0, {(VALUE_WIDTH-1){1'b1}}};

  localparam value_t DECIMAL_CASES [10] = '{0, 1, -1, 9, 10, -10, MOST_POSITIVE,
                                            MOST_NEGATIVE, 1000000000, -999999999};
  localparam value_t HEX_CASES [7] = '{15, 16, -16, MOST_NEGATIVE, MOST_POSITIVE,
                                       32'shdeadbeef, -1};
  localparam value_t BINARY_CASES [5] = '{MOST_NEGATIVE, MOST_POSITIVE, 0, -1, 5};

  typedef struct packed {
    char_t character;
    logic  last;
  } text_char_t;

  class radix_text_scoreboard;
    logic [BASE_W-1:0]     base_size;
    logic [CFG_DATA_W-1:0] chars_low;
    logic [CFG_DATA_W-1:0] chars_high;
    text_char_t            expected_chars[$];
    int unsigned           mismatches;

    function new();
      base_size  = BASE_SIZE_RST;
      chars_low  = DIGITS_LOW_RST;
      chars_high = DIGITS_HIGH_RST;
      mismatches = 0;
    endfunction

    function void write_register(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_BASE_SIZE:   base_size = data[BASE_W-1:0];
        CFG_DIGITS_LOW:  chars_low = data;
        CFG_DIGITS_HIGH: chars_high = data;
        default: ;
      endcase
    endfunction

    function int unsigned radix();
      if (base_size < 2) return 2;
      if (base_size > MAX_BASE) return MAX_BASE;
      return base_size;
    endfunction

    function char_t digit_char(int unsigned d);
      if (d < 8) return chars_low[CHAR_W*d +: CHAR_W];
      return chars_high[CHAR_W*(d-8) +: CHAR_W];
    endfunction

    function void note_value(value_t v);
      mag_t        mag;
      int unsigned r;
      int unsigned digits[$];
      text_char_t  c;
      r = radix();
      mag = v[VALUE_WIDTH-1] ? ~v + 1'b1 : v;
      do begin
        digits.push_front(mag % r);
        mag = mag / r;
      end while (mag != 0);
      if (v[VALUE_WIDTH-1]) begin
        c.character = MINUS_CHAR;
        c.last = 1'b0;
        expected_chars.push_back(c);
      end
      foreach (digits[i]) begin
        c.character = digit_char(digits[i]);
        c.last = (i == digits.size() - 1);
        expected_chars.push_back(c);
      end
    endfunction

    function void check_char(char_t character, logic last);
      text_char_t want;
      if (expected_chars.size() == 0) begin
        $display("%0t: character %h last %b with no request pending", $time, character, last);
        mismatches++;
        return;
      end
      want = expected_chars.pop_front();
      if (character !== want.character) begin
        $display("%0t: character expected %h, got %h", $time, want.character, character);
        mismatches++;
      end
      if (last !== want.last) begin
        $display("%0t: last expected %b, got %b", $time, want.last, last);
        mismatches++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  cfg_idx_t              cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  bit                    in_calm;
  bit                    out_calm;
  int unsigned           idle_cycles = 0;
  radix_text_scoreboard  sb = new();

  sitr_in_if  in_ch ();
  sitr_out_if out_ch ();

  signed_integer_to_radix_text_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic value_t pick_value(int unsigned r);
    longint      p;
    int unsigned k;
    value_t      v;
    case ($urandom_range(0, 5))
      0: v = $urandom();
      1: v = $urandom_range(0, r * r * r);
      2: begin
        case ($urandom_range(0, 3))
          0: v = MOST_NEGATIVE;
          1: v = MOST_POSITIVE;
          2: v = 0;
          default: v = -1;
        endcase
      end
      3: begin
        p = 1;
        k = $urandom_range(1, VALUE_WIDTH - 1);
        repeat (k) if (p * r <= longint'(MOST_POSITIVE)) p = p * r;
        v = value_t'(p + $urandom_range(0, 2) - 1);
      end
      default: v = $urandom() >> $urandom_range(0, VALUE_WIDTH - 1);
    endcase
    if ($urandom_range(0, 1)) v = -v;
    return v;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_alphabet();
    logic [CFG_DATA_W-1:0] a;
    case ($urandom_range(0, 9))
      0: a = '0;
      1: a = '1;
      2, 3, 4: a = {$urandom(), $urandom()};
      default: for (int i = 0; i < CFG_DATA_W / CHAR_W; i++)
        a[CHAR_W*i +: CHAR_W] = $urandom_range(33, 126);
    endcase
    return a;
  endfunction

  task automatic write_register(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.write_register(idx, data);
    @(negedge clk);
  endtask

  task automatic apply_settings(int unsigned base, logic [CFG_DATA_W-1:0] low,
                                logic [CFG_DATA_W-1:0] high, logic [2:0] extra);
    logic [CFG_DATA_W-1:0] base_data;
    base_data = {$urandom(), $urandom()};
    base_data[BASE_W-1:0] = base[BASE_W-1:0];
    write_register(CFG_BASE_SIZE, base_data);
    if (extra[0]) write_register(CFG_DIGITS_LOW, low);
    if (extra[1]) write_register(CFG_DIGITS_HIGH, high);
    if (extra[2]) write_register(CFG_SPARE, {$urandom(), $urandom()});
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (sb.expected_chars.size() != 0) @(negedge clk);
  endtask

  task automatic push_value(value_t v, bit hold_off);
    int unsigned gap;
    gap = in_calm ? 0 : pick_gap();
    if (hold_off && gap == 0) gap = 1;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
      if (hold_off) drain();
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= v;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_value(v);
    @(negedge clk);
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    drain();
  endtask

  initial begin
    int unsigned stall_left;
    int unsigned gap;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready)
        sb.check_char(out_ch.character, out_ch.last);
      @(negedge clk);
      if (out_calm) begin
        out_ch.ready <= 1'b1;
      end else if (stall_left != 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        gap = pick_gap();
        out_ch.ready <= (gap == 0);
        if (gap != 0) stall_left = gap - 1;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned bases[12];
    in_ch.valid <= 1'b0;
    in_ch.value <= '0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_BASE_SIZE;
    cfg_data <= '0;
    rst_n <= 1'b0;
    in_calm = 1'b0;
    out_calm = 1'b0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // reset radix and alphabet first
    foreach (DECIMAL_CASES[i]) push_value(DECIMAL_CASES[i], 1'b0);
    settle();

    apply_settings(16, HEX_LOW, HEX_HIGH, 3'b011);
    foreach (HEX_CASES[i]) push_value(HEX_CASES[i], 1'b0);
    settle();

    in_calm = 1'b1;
    out_calm = 1'b1;
    apply_settings(2, '1, '0, 3'b111);
    foreach (BINARY_CASES[i]) push_value(BINARY_CASES[i], 1'b0);
    settle();

    bases = '{2, 16, 0, 1, 31, 17, 3, 7, 8, 12, 0, 0};
    bases[10] = $urandom_range(2, MAX_BASE);
    bases[11] = $urandom_range(0, 31);
    foreach (bases[p]) begin
      in_calm = ($urandom_range(0, 3) == 0);
      out_calm = ($urandom_range(0, 3) == 0);
      apply_settings(bases[p], pick_alphabet(), pick_alphabet(),
                     (p == 0) ? 3'b011 : 3'($urandom_range(0, 3)));
      repeat (PHASE_ITEMS) push_value(pick_value(sb.radix()), $urandom_range(0, 39) == 0);
      settle();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.expected_chars.size() != 0) begin
      $display("%0t: %0d characters expected, none arrived", $time, sb.expected_chars.size());
      sb.mismatches++;
    end
    if (sb.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
